[hdl/bdat_pkg.sv]
// Shared constants and types for the bounded deadline admission table.
// Used by bdat_cell and bounded_deadline_admission_table; depends on nothing.
package bdat_pkg;

    localparam int MAX_ACTIVE = 64;
    localparam int MAX_JOBS   = 262144;

    localparam int SLOT_W = (MAX_ACTIVE > 1) ? $clog2(MAX_ACTIVE) : 1;
    localparam int CNT_W  = $clog2(MAX_ACTIVE + 1);
    localparam int ID_W   = 18;
    localparam int TIME_W = 31;
    localparam int KEY_W  = TIME_W + ID_W;
    localparam int FIN_W  = 19;
    localparam int LIM_W  = 7;

    localparam int FIN_CAP = (MAX_JOBS < (2 ** FIN_W) - 1) ? MAX_JOBS : (2 ** FIN_W) - 1;

    localparam logic OP_END   = 1'b0;
    localparam logic OP_START = 1'b1;

    // Ordering key of one job: end time above id, compared as one unsigned word.
    typedef logic [KEY_W-1:0] key_t;

    // Running maximum that travels along the row during an eviction search.
    typedef struct packed {
        logic              tok;
        logic              vld;
        key_t              key;
        logic [SLOT_W-1:0] slot;
    } scan_t;

    typedef struct packed {
        logic wr;
        logic clr;
    } cell_cmd_t;

endpackage

[hdl/bdat_cell.sv]
// One slot of the admission table: holds a job and takes part in the maximum search.
// Depends on bdat_pkg.
module bdat_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bdat_pkg::cell_cmd_t           cmd,
    input  bdat_pkg::key_t                wr_key,
    input  logic [bdat_pkg::ID_W-1:0]     probe_id,
    input  logic [bdat_pkg::SLOT_W-1:0]   slot_idx,
    input  bdat_pkg::scan_t               scan_in,
    output logic                          vld,
    output logic                          match,
    output bdat_pkg::scan_t               scan_out
);
    import bdat_pkg::*;

    logic  vld_reg, vld_next;
    key_t  key_reg, key_next;
    scan_t scan_reg, scan_next;
    logic  own_wins;

    always_comb begin
        vld_next = vld_reg;
        key_next = key_reg;
        if (cmd.clr) begin
            vld_next = 1'b0;
        end else if (cmd.wr) begin
            vld_next = 1'b1;
            key_next = wr_key;
        end
    end

    // Strictly greater only, so the lowest slot keeps a tie.
    assign own_wins = vld_reg && (!scan_in.vld || (key_reg > scan_in.key));

    always_comb begin
        scan_next     = scan_in;
        scan_next.tok = scan_in.tok;
        if (own_wins) begin
            scan_next.vld  = 1'b1;
            scan_next.key  = key_reg;
            scan_next.slot = slot_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= 1'b0;
            scan_reg <= '0;
        end else begin
            vld_reg  <= vld_next;
            scan_reg <= scan_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign vld      = vld_reg;
    assign match    = vld_reg && (key_reg[ID_W-1:0] == probe_id);
    assign scan_out = scan_reg;

endmodule

[hdl/bounded_deadline_admission_table.sv]
// Top level of the bounded deadline admission table: stream ports, control and a row of slots.
// Depends on bdat_pkg and bdat_cell.
//
// The block admits jobs against a limit on how many may be active at once. Each request is
// either an end event (tuser low) or a start event (tuser high) carrying a job id and its end
// time, and every request produces exactly one result carrying the running finished count and
// flags for a completion or an eviction. The table is a row of MAX_ACTIVE slot cells. An end
// event clears the lowest slot holding the job id, and a start event with room left fills the
// lowest free slot. A start event that finds the table at its limit must locate the job
// with the largest (end time, id) pair: a search token walks the row one cell per cycle, each
// cell passing the running maximum to its neighbour, and no new request is accepted until the
// search and the replacement are done. The new job then replaces the largest one, or is itself
// rejected when no held pair is strictly larger. A limit of zero sends every start to the
// search, and a limit above MAX_ACTIVE behaves as MAX_ACTIVE. The limit
// register is written through the cfg channel, which is always ready; it resets to 64 and is
// meant to be written only while the block is idle. Results sit in an output register, so the
// next request is taken as soon as the previous result is leaving.
module bounded_deadline_admission_table (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Input requests.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [55:0]               s_tdata,   // [17:0] job_id, [48:18] end_time, zero above
    input  logic                      s_tuser,   // [0] opcode
    // Results.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata,   // [18:0] finished_total, [36:19] dropped_job
    output logic [1:0]                m_tuser,   // [0] completed, [1] dropped
    // Limit register write channel.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [bdat_pkg::LIM_W-1:0] cfg_data
);
    import bdat_pkg::*;

    localparam int M_TDATA_W = 40;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_EVICT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [LIM_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FIN_W-1:0]  fin_reg, fin_next;
    key_t              req_key_reg, req_key_next;
    scan_t             best_reg, best_next;

    logic              m_valid_reg, m_valid_next;
    logic [FIN_W-1:0]  out_fin_reg, out_fin_next;
    logic              out_comp_reg, out_comp_next;
    logic              out_drop_reg, out_drop_next;
    logic [ID_W-1:0]   out_job_reg, out_job_next;

    logic [MAX_ACTIVE-1:0] cell_vld, cell_match, cell_wr, cell_clr;
    logic [MAX_ACTIVE-1:0] free_vec, free_1h, match_1h;
    scan_t                 chain [MAX_ACTIVE+1];
    key_t                  wr_key, in_key;
    logic [ID_W-1:0]       in_id;
    logic [LIM_W-1:0]      lim;
    logic                  has_room, out_free, in_acc, scan_start;

    assign in_id  = s_tdata[ID_W-1:0];
    assign in_key = {s_tdata[KEY_W-1:ID_W], s_tdata[ID_W-1:0]};

    assign lim      = (32'(limit_reg) > MAX_ACTIVE) ? LIM_W'(MAX_ACTIVE) : limit_reg;
    assign has_room = 32'(count_reg) < 32'(lim);
    assign out_free = !m_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;

    // Lowest free slot and lowest slot holding the probed id, as one-hot vectors.
    assign free_vec = ~cell_vld;
    assign free_1h  = free_vec & (~free_vec + MAX_ACTIVE'(1));
    assign match_1h = cell_match & (~cell_match + MAX_ACTIVE'(1));

    assign cfg_ready  = 1'b1;
    assign limit_next = (cfg_valid && cfg_ready) ? cfg_data : limit_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        fin_next      = fin_reg;
        req_key_next  = req_key_reg;
        best_next     = best_reg;
        cell_wr       = '0;
        cell_clr      = '0;
        wr_key        = in_key;
        scan_start    = 1'b0;
        out_fin_next  = out_fin_reg;
        out_comp_next = out_comp_reg;
        out_drop_next = out_drop_reg;
        out_job_next  = out_job_reg;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (s_tuser == OP_END) begin
                        // End of a job: remove it if it is still held.
                        out_comp_next = |cell_match;
                        out_drop_next = 1'b0;
                        out_job_next  = '0;
                        out_fin_next  = fin_reg;
                        m_valid_next  = 1'b1;
                        if (|cell_match) begin
                            cell_clr   = match_1h;
                            count_next = count_reg - CNT_W'(1);
                            if (32'(fin_reg) < FIN_CAP) begin
                                fin_next     = fin_reg + FIN_W'(1);
                                out_fin_next = fin_reg + FIN_W'(1);
                            end
                        end
                    end else if (has_room) begin
                        // Room below the limit: take the lowest free slot.
                        cell_wr       = free_1h;
                        count_next    = count_reg + CNT_W'(1);
                        out_comp_next = 1'b0;
                        out_drop_next = 1'b0;
                        out_job_next  = '0;
                        out_fin_next  = fin_reg;
                        m_valid_next  = 1'b1;
                    end else begin
                        // At the limit: search the row for the largest job first.
                        req_key_next = in_key;
                        scan_start   = 1'b1;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (chain[MAX_ACTIVE].tok) begin
                    best_next  = chain[MAX_ACTIVE];
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if (out_free) begin
                    wr_key        = req_key_reg;
                    out_comp_next = 1'b0;
                    out_drop_next = 1'b1;
                    out_fin_next  = fin_reg;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                    if (best_reg.vld && (best_reg.key > req_key_reg)) begin
                        // The held job is larger: it makes way for the new one.
                        cell_wr      = MAX_ACTIVE'(1) << best_reg.slot;
                        out_job_next = best_reg.key[ID_W-1:0];
                    end else begin
                        out_job_next = req_key_reg[ID_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign chain[0] = {scan_start, 1'b0, KEY_W'(0), SLOT_W'(0)};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ACTIVE; gi++) begin : g_cell
            bdat_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .cmd      ({cell_wr[gi], cell_clr[gi]}),
                .wr_key   (wr_key),
                .probe_id (in_id),
                .slot_idx (SLOT_W'(gi)),
                .scan_in  (chain[gi]),
                .vld      (cell_vld[gi]),
                .match    (cell_match[gi]),
                .scan_out (chain[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            limit_reg   <= LIM_W'(64);
            count_reg   <= '0;
            fin_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            limit_reg   <= limit_next;
            count_reg   <= count_next;
            fin_reg     <= fin_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_key_reg  <= req_key_next;
        best_reg     <= best_next;
        out_fin_reg  <= out_fin_next;
        out_comp_reg <= out_comp_next;
        out_drop_reg <= out_drop_next;
        out_job_reg  <= out_job_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_job_reg, out_fin_reg});
    assign m_tuser  = {out_drop_reg, out_comp_reg};

    // The occupancy counter must agree with the slots actually held.
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(cell_vld)))
        else $error("occupancy count differs from held slots");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= MAX_ACTIVE)
        else $error("occupancy count above table size");

    a_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_tready)
        else $error("request accepted during an eviction search");

    a_one_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cell_wr | cell_clr))
        else $error("more than one slot updated in a cycle");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result flags both completion and eviction");

endmodule

[sim/bounded_deadline_admission_table_tb.sv]
// Self-checking testbench for bounded_deadline_admission_table: random and directed requests,
// checked against an in-bench model of the admission table. Depends on bdat_pkg and the RTL.
module bounded_deadline_admission_table_tb;
    import bdat_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 80;   // beyond the longest eviction search

    typedef struct packed {
        logic              op;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] end_time;
    } job_event_t;

    typedef struct packed {
        logic [FIN_W-1:0] finished_total;
        logic             completed;
        logic             dropped;
        logic [ID_W-1:0]  dropped_job;
    } admit_outcome_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [55:0]       s_tdata   = '0;   // [17:0] job_id, [48:18] end_time, zero above
    logic              s_tuser   = 1'b0; // [0] opcode
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;          // [18:0] finished_total, [36:19] dropped_job
    logic [1:0]        m_tuser;          // [0] completed, [1] dropped
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LIM_W-1:0]  cfg_data  = '0;

    // Model of the table, kept in step with every accepted request and limit write.
    logic              slot_live [MAX_ACTIVE];
    logic [TIME_W-1:0] slot_end  [MAX_ACTIVE];
    logic [ID_W-1:0]   slot_id   [MAX_ACTIVE];
    int                live_count;
    logic [FIN_W-1:0]  done_count;
    logic [LIM_W-1:0]  limit_reg;

    job_event_t        event_q[$];     // requests waiting for the driver
    admit_outcome_t    outcome_q[$];   // predicted results not yet seen on the output
    logic [ID_W-1:0]   live_ids[$];    // ids the stimulus believes are still running
    logic [TIME_W-1:0] clock_now;

    int  n_queued, n_accepted, n_errors, n_completed, n_dropped, n_cfg, cycles;
    int  idle_left, stall_left;
    bit  steady = 1'b0;                // when set, neither side inserts gaps
    bit  s_took = 1'b0, cfg_took = 1'b0;

    bounded_deadline_admission_table DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // Mostly no gap, sometimes a short one and now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Applies one request to the model and returns the result it should produce. An end
    // request clears the lowest live slot with that id. A start either fills the lowest free
    // slot or, with the table at its limit, displaces the largest (end time, id) pair; the
    // new job is itself refused when no live pair is strictly larger than its own.
    task automatic admit_event(input job_event_t ev, output admit_outcome_t res);
        int  lim, best, i;
        bit  hit;
        lim  = (limit_reg > MAX_ACTIVE) ? MAX_ACTIVE : limit_reg;
        res  = '0;
        hit  = 1'b0;
        best = -1;
        if (ev.op == OP_END) begin
            for (i = 0; i < MAX_ACTIVE && !hit; i++) begin
                if (slot_live[i] && slot_id[i] == ev.job_id) begin
                    slot_live[i] = 1'b0;
                    live_count--;
                    if (done_count < FIN_CAP) done_count++;
                    res.completed = 1'b1;
                    hit = 1'b1;
                end
            end
        end else if (live_count < lim) begin
            for (i = 0; i < MAX_ACTIVE && !hit; i++) begin
                if (!slot_live[i]) begin
                    slot_live[i] = 1'b1;
                    slot_end[i]  = ev.end_time;
                    slot_id[i]   = ev.job_id;
                    live_count++;
                    hit = 1'b1;
                end
            end
        end else begin
            // Strictly greater only, so the lowest of equal largest pairs wins.
            for (i = 0; i < MAX_ACTIVE; i++) begin
                if (slot_live[i] && (best < 0 ||
                        {slot_end[i], slot_id[i]} > {slot_end[best], slot_id[best]}))
                    best = i;
            end
            res.dropped = 1'b1;
            if (best < 0 || !({slot_end[best], slot_id[best]} > {ev.end_time, ev.job_id})) begin
                res.dropped_job = ev.job_id;
            end else begin
                res.dropped_job = slot_id[best];
                slot_end[best]  = ev.end_time;
                slot_id[best]   = ev.job_id;
            end
        end
        res.finished_total = done_count;
    endtask

    // Driver: presents queued requests at the falling edge with random gaps between them,
    // and throttles the result side with random stalls.
    always @(negedge aclk) begin
        job_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || s_took) begin
                if (idle_left > 0) begin
                    s_tvalid  <= 1'b0;
                    idle_left--;
                end else if (event_q.size() > 0) begin
                    ev        = event_q.pop_front();
                    s_tvalid  <= 1'b1;
                    s_tdata   <= {7'b0, ev.end_time, ev.job_id};
                    s_tuser   <= ev.op;
                    idle_left = gap_len();
                end else begin
                    s_tvalid  <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = gap_len();
            end
        end
    end

    // Monitor: at each rising edge checks a leaving result against the oldest prediction,
    // then takes any accepted request or limit write into the model.
    always @(posedge aclk) begin
        admit_outcome_t want, seen;
        job_event_t     ev;
        s_took   <= aresetn && s_tvalid && s_tready;
        cfg_took <= aresetn && cfg_valid && cfg_ready;
        if (aresetn && m_tvalid && m_tready) begin
            seen = {m_tdata[18:0], m_tuser[0], m_tuser[1], m_tdata[36:19]};
            n_completed += seen.completed;
            n_dropped   += seen.dropped;
            if (outcome_q.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, seen);
                n_errors++;
            end else begin
                want = outcome_q.pop_front();
                if (seen.finished_total !== want.finished_total) begin
                    $display("%0t: finished_total expected %0d actual %0d", $time,
                             want.finished_total, seen.finished_total);
                    n_errors++;
                end
                if (seen.completed !== want.completed) begin
                    $display("%0t: completed expected %0b actual %0b", $time,
                             want.completed, seen.completed);
                    n_errors++;
                end
                if (seen.dropped !== want.dropped) begin
                    $display("%0t: dropped expected %0b actual %0b", $time,
                             want.dropped, seen.dropped);
                    n_errors++;
                end
                if (seen.dropped_job !== want.dropped_job) begin
                    $display("%0t: dropped_job expected %0h actual %0h", $time,
                             want.dropped_job, seen.dropped_job);
                    n_errors++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            ev = {s_tuser, s_tdata[17:0], s_tdata[48:18]};
            admit_event(ev, want);
            outcome_q.insert(outcome_q.size(), want);
            n_accepted++;
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            limit_reg = cfg_data;
            n_cfg++;
        end
    end

    // Hard stop should the block hang.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("bounded_deadline_admission_table_tb: errors");
            $finish;
        end
    end

    task automatic queue_event(input logic op, input logic [ID_W-1:0] id,
                               input logic [TIME_W-1:0] et);
        job_event_t ev;
        ev = '{op, id, et};
        event_q.insert(event_q.size(), ev);
        n_queued++;
    endtask

    // End times cluster near the present, with ties now and then and a few anywhere at all.
    function automatic logic [TIME_W-1:0] pick_end();
        int m;
        m = $urandom_range(0, 9);
        if (m == 0) return TIME_W'($urandom());
        if (m < 4) return TIME_W'(clock_now + $urandom_range(0, 3));
        return TIME_W'(clock_now + $urandom_range(0, 5000));
    endfunction

    // Mostly well-formed traffic: new jobs and ends of running ones, with a share of
    // repeated ids and ends for ids that are not running.
    task automatic gen_traffic(input int n, input int start_pct);
        int               k, r, pick;
        logic [ID_W-1:0]  id;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (live_ids.size() == 0 || r < start_pct) begin
                id = ID_W'($urandom_range(0, (1 << ID_W) - 1));
                live_ids.insert(live_ids.size(), id);
                queue_event(OP_START, id, pick_end());
            end else begin
                r    = $urandom_range(0, 99);
                pick = $urandom_range(0, live_ids.size() - 1);
                if (r < 75) begin
                    queue_event(OP_END, live_ids[pick], '0);
                    live_ids.delete(pick);
                end else if (r < 88) begin
                    queue_event(OP_START, live_ids[pick], pick_end());
                end else begin
                    queue_event(OP_END, ID_W'($urandom_range(0, (1 << ID_W) - 1)),
                                TIME_W'($urandom()));
                end
            end
            clock_now += TIME_W'($urandom_range(0, 40));
        end
    endtask

    // Holds the sender back until every request has been taken and every result seen.
    task automatic drain();
        do @(negedge aclk); while (n_accepted != n_queued || outcome_q.size() != 0);
    endtask

    task automatic write_limit(input logic [LIM_W-1:0] value);
        drain();
        repeat (4) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge aclk); while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [LIM_W-1:0] lim, input int n, input int start_pct,
                             input bit no_gaps);
        write_limit(lim);
        steady <= no_gaps;
        @(posedge aclk);
        gen_traffic(n, start_pct);
    endtask

    initial begin
        for (int i = 0; i < MAX_ACTIVE; i++) begin
            slot_live[i] = 1'b0;
            slot_end[i]  = '0;
            slot_id[i]   = '0;
        end
        live_count = 0;
        done_count = '0;
        limit_reg  = 7'd64;
        clock_now  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Default limit: ends on an empty table, extreme ids and times, a repeated id.
        queue_event(OP_END,   18'd5,      '0);
        queue_event(OP_START, 18'd0,      31'd0);
        queue_event(OP_START, 18'h3FFFF,  31'h7FFF_FFFF);
        queue_event(OP_START, 18'd7,      31'd100);
        queue_event(OP_START, 18'd7,      31'd200);
        queue_event(OP_END,   18'd7,      31'h7FFF_FFFF);
        queue_event(OP_END,   18'd0,      '0);
        queue_event(OP_END,   18'd0,      '0);

        // Limit of two with two jobs live: the largest pair gives way, a newcomer that is
        // itself the largest is refused, and an exact tie refuses the newcomer.
        write_limit(7'd2);
        @(posedge aclk);
        queue_event(OP_START, 18'd3,      31'd50);
        queue_event(OP_START, 18'd9,      31'd1000);
        queue_event(OP_START, 18'd7,      31'd200);
        queue_event(OP_END,   18'd7,      '0);
        queue_event(OP_START, 18'd4,      31'd50);
        queue_event(OP_START, 18'd2,      31'd50);
        queue_event(OP_START, 18'd2,      31'd50);

        // Limit of zero: every start costs a job, the newcomer or a larger live one.
        write_limit(7'd0);
        @(posedge aclk);
        queue_event(OP_START, 18'd11,     31'd5);
        queue_event(OP_START, 18'h3FFFF,  31'h7FFF_FFFF);
        queue_event(OP_END,   18'h3FFFF,  '0);
        queue_event(OP_END,   18'd2,      '0);
        queue_event(OP_START, 18'd12,     31'd1);

        // Random phases; the top value is clamped to the table size, and the drop to four
        // follows a fill, so the limit sits below the live count for a while.
        run_phase(7'd127, 90, 80, 1'b0);
        run_phase(7'd64,  50, 55, 1'b1);
        run_phase(7'd4,   50, 50, 1'b0);
        run_phase(7'd0,   20, 60, 1'b0);
        run_phase(7'd1,   40, 55, 1'b0);
        run_phase(7'd9,   60, 55, 1'b1);
        run_phase(7'd33,  60, 60, 1'b0);
        run_phase(7'd64,  80, 55, 1'b0);

        drain();
        repeat (SETTLE) @(posedge aclk);
        $display("%0d requests over %0d limit settings: %0d completions, %0d evictions.",
                 n_accepted, n_cfg, n_completed, n_dropped);
        if (n_errors == 0) begin
            $display("bounded_deadline_admission_table_tb: clean");
        end else begin
            $display("bounded_deadline_admission_table_tb: errors");
        end
        $finish;
    end

endmodule

[bounded_deadline_admission_table.f]
hdl/bdat_pkg.sv
hdl/bdat_cell.sv
hdl/bounded_deadline_admission_table.sv
sim/bounded_deadline_admission_table_tb.sv
